FILE: hw/rtl/sdcmd_pkg.sv
// sdcmd_pkg: request structs, response-kind and status codes, CRC7 step.
// Used by every module of the SD CMD-line engine; no dependencies.
`timescale 1ns / 1ps

package sdcmd_pkg;

  typedef struct packed {
    logic        command;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [2:0]  resp_kind;
    logic        cmd_line;
  } in_item_t;

  typedef struct packed {
    logic       cmd_drive;
    logic       cmd_enable;
    logic       byte_valid;
    logic [7:0] resp_byte;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_R1   = 3'd1;
  localparam logic [2:0] KIND_R2   = 3'd2;
  localparam logic [2:0] KIND_R3   = 3'd3;
  localparam logic [2:0] KIND_R6   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_CRC     = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  localparam logic [7:0] FRAME_BITS    = 8'd48;
  localparam logic [7:0] R2_BITS       = 8'd136;
  localparam logic [7:0] CRC_BITS      = 8'd40;
  localparam logic [7:0] END_BIT_POS   = 8'd47;
  localparam logic [7:0] OCR_READY_POS = 8'd8;

  localparam logic [6:0]  CRC7_POLY       = 7'h09;
  localparam logic [15:0] TIMEOUT_DEFAULT = 16'd256;
  localparam logic        REG_TIMEOUT     = 1'b0;

  // One serial CRC7 step, x^7 + x^3 + 1
  function automatic logic [6:0] crc7_step(input logic [6:0] crc, input logic bit_in);
    logic fb;
    fb = crc[6] ^ bit_in;
    return {crc[5:0], 1'b0} ^ (fb ? CRC7_POLY : 7'h00);
  endfunction

endpackage

FILE: hw/rtl/sd_cmd_line_engine_crc7_core.sv
// SD CMD-line host engine with CRC7: input register, sequencer, result register.
// Accepted requests pass through the input register, then the sequencer, then the result
// register; throughput one request per cycle while the result channel does not stall,
// set by the combinational sequencer step between the two registers.
// Synchronous active-low reset: pipeline empty, sequencer idle, timeout = 256.
// Depends on sdcmd_pkg, sdcmd_regs, sdcmd_engine.
`timescale 1ns / 1ps

module sd_cmd_line_engine_crc7_core import sdcmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_full_r, in_full_nxt;
  in_item_t    in_item_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;
  out_item_t   result;
  logic [15:0] start_timeout;
  logic        adv, in_take;

  sdcmd_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start_timeout(start_timeout)
  );

  sdcmd_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (adv),
    .item         (in_item_r),
    .start_timeout(start_timeout),
    .result       (result)
  );

  // the held request moves on whenever the result register is free or draining
  assign adv      = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall = in_full_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_take) in_full_nxt = 1'b1;
    else if (adv) in_full_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_item_r <= in_data;
    if (adv) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

FILE: hw/rtl/sdcmd_regs.sv
// sdcmd_regs: APB-style register file holding the start-bit timeout.
// Depends on sdcmd_pkg.
`timescale 1ns / 1ps

module sdcmd_regs import sdcmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] start_timeout
);

  logic [15:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_DEFAULT;
    end else if (psel && penable && pwrite && paddr == REG_TIMEOUT) begin
      timeout_r <= pwdata[15:0];
    end
  end

  assign pready        = 1'b1;
  assign prdata        = (paddr == REG_TIMEOUT) ? {16'h0000, timeout_r} : 32'h0;
  assign start_timeout = timeout_r;

endmodule

FILE: hw/rtl/sdcmd_engine.sv
// sdcmd_engine: CMD-line sequencer; one request per SD clock tick, result
// produced combinationally from the current state and request. Depends on sdcmd_pkg.
`timescale 1ns / 1ps

module sdcmd_engine import sdcmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  in_item_t    item,
  input  logic [15:0] start_timeout,
  output out_item_t   result
);

  typedef enum logic [1:0] {PH_IDLE, PH_SEND, PH_WAIT, PH_RECV} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [39:0] shift_r, shift_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [6:0]  crc_r, crc_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic        busy_r, busy_nxt;

  phase_t      ph;
  logic [39:0] sh;
  logic [7:0]  cnt, cnt_inc, total;
  logic [6:0]  crc;
  logic [2:0]  kind;
  logic        busy;
  logic [15:0] wait_inc;

  always_comb begin
    // a start request only takes effect from idle, and its first bit goes out at once
    ph   = phase_r;
    sh   = shift_r;
    cnt  = cnt_r;
    crc  = crc_r;
    kind = kind_r;
    busy = busy_r;
    if (phase_r == PH_IDLE && item.command) begin
      ph   = PH_SEND;
      sh   = {2'b01, item.cmd_index, item.argument};
      cnt  = 8'd0;
      crc  = 7'd0;
      kind = item.resp_kind;
      busy = 1'b0;
    end

    phase_nxt = ph;
    shift_nxt = sh;
    cnt_nxt   = cnt;
    crc_nxt   = crc;
    byte_nxt  = byte_r;
    wait_nxt  = wait_r;
    kind_nxt  = kind;
    busy_nxt  = busy;
    result    = '0;
    result.cmd_drive = 1'b1;
    cnt_inc   = cnt + 8'd1;
    wait_inc  = wait_r + 16'd1;
    total     = (kind == KIND_R2) ? R2_BITS : FRAME_BITS;

    case (ph)
      PH_SEND: begin
        result.cmd_enable = 1'b1;
        // header bits feed the CRC as they leave; CRC then shifts out itself
        if (cnt < CRC_BITS) begin
          result.cmd_drive = sh[39];
          crc_nxt          = crc7_step(crc, sh[39]);
          shift_nxt        = {sh[38:0], 1'b0};
        end else if (cnt < END_BIT_POS) begin
          result.cmd_drive = crc[6];
          crc_nxt          = {crc[5:0], 1'b0};
        end else begin
          result.cmd_drive = 1'b1;
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc >= FRAME_BITS) begin
          cnt_nxt = 8'd0;
          if (kind == KIND_NONE) begin
            result.done_res = 1'b1;
            result.status   = ST_OK;
            phase_nxt       = PH_IDLE;
          end else begin
            wait_nxt  = 16'd0;
            phase_nxt = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        if (!item.cmd_line) begin
          byte_nxt  = 8'd0;
          crc_nxt   = 7'd0;
          cnt_nxt   = 8'd1;
          phase_nxt = PH_RECV;
        end else begin
          wait_nxt = wait_inc;
          // a zero timeout trips on the first high sample
          if (wait_inc >= start_timeout) begin
            result.done_res = 1'b1;
            result.status   = ST_TIMEOUT;
            phase_nxt       = PH_IDLE;
          end
        end
      end
      PH_RECV: begin
        if (cnt < CRC_BITS) begin
          crc_nxt = crc7_step(crc, item.cmd_line);
        end
        if (kind == KIND_R3 && cnt == OCR_READY_POS && !item.cmd_line) begin
          busy_nxt = 1'b1;
        end
        byte_nxt = {byte_r[6:0], item.cmd_line};
        cnt_nxt  = cnt_inc;
        if (cnt_inc[2:0] == 3'd0) begin
          result.byte_valid = 1'b1;
          result.resp_byte  = byte_nxt;
        end
        if (cnt_inc >= total) begin
          result.done_res = 1'b1;
          if (kind == KIND_R1 || kind == KIND_R6) begin
            if (byte_nxt != {crc_nxt, 1'b1}) result.status = ST_CRC;
          end else if (kind == KIND_R3) begin
            if (busy_nxt) result.status = ST_BUSY;
          end
          cnt_nxt   = 8'd0;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      shift_r <= '0;
      cnt_r   <= '0;
      crc_r   <= '0;
      byte_r  <= '0;
      wait_r  <= '0;
      kind_r  <= '0;
      busy_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      byte_r  <= byte_nxt;
      wait_r  <= wait_nxt;
      kind_r  <= kind_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

FILE: hw/rtl/sdcmd_checker.sv
// sdcmd_checker: port-level assertions on the result channel, bound to the core.
// Depends on sdcmd_pkg and sd_cmd_line_engine_crc7_core.
`timescale 1ns / 1ps

module sdcmd_checker import sdcmd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled response changed");

  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.cmd_enable |-> out_data.cmd_drive)
    else $error("released line not driven high");

  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |-> out_data.status == ST_OK)
    else $error("status set without done");

  a_byte_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_data.byte_valid || out_data.cmd_enable) |->
      out_data.resp_byte == 8'h00 && !(out_data.byte_valid && out_data.cmd_enable))
    else $error("response byte while not receiving");

endmodule

bind sd_cmd_line_engine_crc7_core sdcmd_checker u_chk (.*);
